/* design/box3_pkg.sv */
// shared constants and types for the 3x3 rgb box filter
package box3_pkg;

  // default and field widths
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int CH_W          = 8;
  localparam int ROW_W         = 12;
  localparam int COL_OUT_W     = 10;
  localparam int FW_W          = 11;
  localparam int FH_W          = 12;
  localparam int SUM_W         = 12;
  localparam int NSLOT         = 3;

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;
  localparam logic [FW_W-1:0] FW_RESET = 11'd800;
  localparam logic [FH_W-1:0] FH_RESET = 12'd600;
  localparam int MIN_SIZE = 3;

  // divide by nine: (sum * 3641) >> 15 is exact for sums below 2300
  localparam logic [SUM_W-1:0] ROUND_BIAS  = 12'd4;
  localparam logic [SUM_W-1:0] RECIP9      = 12'd3641;
  localparam int               RECIP_SHIFT = 15;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    pix_t                 pix;
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] column;
  } result_t;

  // up to three results of one pixel, delivered lowest slot first
  typedef struct packed {
    result_t [NSLOT-1:0] slot;
    logic [NSLOT-1:0]    mask;
    logic                frame_end;
  } bundle_t;

endpackage

/* design/box3_ifs.sv */
// pixel and result channel interfaces
interface box3_pix_if;
  logic                      valid;
  logic                      ready;
  logic [box3_pkg::CH_W-1:0] red_in;
  logic [box3_pkg::CH_W-1:0] green_in;
  logic [box3_pkg::CH_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface box3_res_if;
  logic                           valid;
  logic                           ready;
  logic [box3_pkg::CH_W-1:0]      red_out;
  logic [box3_pkg::CH_W-1:0]      green_out;
  logic [box3_pkg::CH_W-1:0]      blue_out;
  logic [box3_pkg::ROW_W-1:0]     pixel_row;
  logic [box3_pkg::COL_OUT_W-1:0] pixel_column;
  logic                           last_of_item;
  logic                           frame_end;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output pixel_row, output pixel_column, output last_of_item,
                  output frame_end, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input pixel_row, input pixel_column, input last_of_item,
                input frame_end, output ready);
endinterface

/* design/box3_regs.sv */
// frame size registers behind the apb port, with clamped effective sizes
module box3_regs #(
  parameter int MAX_WIDTH = box3_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [box3_pkg::APB_AW-1:0]   paddr,
  input  logic [box3_pkg::APB_DW-1:0]   pwdata,
  output logic [box3_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output logic [$clog2(MAX_WIDTH):0]    eff_width,
  output logic [box3_pkg::FH_W-1:0]     eff_height
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [box3_pkg::FW_W-1:0] frame_width;
  logic [box3_pkg::FH_W-1:0] frame_height;
  logic                      wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= box3_pkg::FW_RESET;
      frame_height <= box3_pkg::FH_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        box3_pkg::REG_WIDTH:  frame_width  <= pwdata[box3_pkg::FW_W-1:0];
        box3_pkg::REG_HEIGHT: frame_height <= pwdata[box3_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[2])
      box3_pkg::REG_WIDTH:  prdata = box3_pkg::APB_DW'(frame_width);
      box3_pkg::REG_HEIGHT: prdata = box3_pkg::APB_DW'(frame_height);
      default:              prdata = '0;
    endcase
  end

  // width clamped to 3..MAX_WIDTH
  always_comb begin
    if (int'(frame_width) < box3_pkg::MIN_SIZE) begin
      eff_width = (CW+1)'(box3_pkg::MIN_SIZE);
    end else if (int'(frame_width) > MAX_WIDTH) begin
      eff_width = (CW+1)'(MAX_WIDTH);
    end else begin
      eff_width = (CW+1)'(frame_width);
    end
  end

  // height clamped to at least 3
  always_comb begin
    if (int'(frame_height) < box3_pkg::MIN_SIZE) begin
      eff_height = box3_pkg::FH_W'(box3_pkg::MIN_SIZE);
    end else begin
      eff_height = frame_height;
    end
  end

endmodule

/* design/box3_front.sv */
// raster counters, two line stores and the input register
module box3_front #(
  parameter int MAX_WIDTH = box3_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  box3_pix_if.sink                      pixels,
  input  logic [$clog2(MAX_WIDTH):0]    eff_width,
  input  logic [box3_pkg::FH_W-1:0]     eff_height,
  input  logic                          s1_advance,
  output logic                          s1_valid,
  output box3_pkg::pix_t                s1_pix,
  output box3_pkg::pix_t                s1_older,
  output box3_pkg::pix_t                s1_newer,
  output logic [box3_pkg::ROW_W-1:0]    s1_row,
  output logic [$clog2(MAX_WIDTH)-1:0]  s1_col
);

  localparam int CW = $clog2(MAX_WIDTH);

  box3_pkg::pix_t older_line [MAX_WIDTH];
  box3_pkg::pix_t newer_line [MAX_WIDTH];

  logic [CW-1:0]                  col_count;
  logic [box3_pkg::ROW_W-1:0]     row_count;
  logic [CW-1:0]                  c_cur;
  logic [box3_pkg::ROW_W-1:0]     r_cur;
  logic [box3_pkg::ROW_W:0]       r_step;
  logic [CW:0]                    c_inc;
  logic [box3_pkg::ROW_W:0]       r_inc;
  logic [CW-1:0]                  col_count_next;
  logic [box3_pkg::ROW_W-1:0]     row_count_next;
  logic                           accept;
  box3_pkg::pix_t                 x;

  assign pixels.ready = !s1_valid || s1_advance;
  assign accept       = pixels.valid && pixels.ready;
  assign x            = '{red: pixels.red_in, green: pixels.green_in, blue: pixels.blue_in};

  // position of the incoming pixel, normalized against the current size
  always_comb begin
    if ({1'b0, col_count} >= eff_width) begin
      c_cur  = '0;
      r_step = {1'b0, row_count} + 1'b1;
    end else begin
      c_cur  = col_count;
      r_step = {1'b0, row_count};
    end
    if (r_step >= {1'b0, eff_height}) begin
      r_cur = '0;
    end else begin
      r_cur = r_step[box3_pkg::ROW_W-1:0];
    end
  end

  // position of the pixel after it
  always_comb begin
    c_inc = {1'b0, c_cur} + 1'b1;
    r_inc = {1'b0, r_cur} + 1'b1;
    if (c_inc >= eff_width) begin
      col_count_next = '0;
      if (r_inc >= {1'b0, eff_height}) begin
        row_count_next = '0;
      end else begin
        row_count_next = r_inc[box3_pkg::ROW_W-1:0];
      end
    end else begin
      col_count_next = c_inc[CW-1:0];
      row_count_next = r_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= x;
      s1_row <= r_cur;
      s1_col <= c_cur;
    end
  end

  // row two above: read on transfer, refilled from the row above as the pixel leaves
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_older <= older_line[c_cur];
    end
    if (s1_advance) begin
      older_line[s1_col] <= s1_newer;
    end
  end

  // row above: read on transfer, refilled with the pixel itself as it leaves
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_newer <= newer_line[c_cur];
    end
    if (s1_advance) begin
      newer_line[s1_col] <= s1_pix;
    end
  end

endmodule

/* design/box3_window.sv */
// column window, 3x3 mean and result selection for the pixel in the input register
module box3_window #(
  parameter int MAX_WIDTH = box3_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          s1_valid,
  input  box3_pkg::pix_t                s1_pix,
  input  box3_pkg::pix_t                s1_older,
  input  box3_pkg::pix_t                s1_newer,
  input  logic [box3_pkg::ROW_W-1:0]    s1_row,
  input  logic [$clog2(MAX_WIDTH)-1:0]  s1_col,
  input  logic [$clog2(MAX_WIDTH):0]    eff_width,
  input  logic [box3_pkg::FH_W-1:0]     eff_height,
  input  logic                          bundle_free,
  output logic                          s1_advance,
  output logic                          bundle_load,
  output box3_pkg::bundle_t             new_bundle
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam logic [CW-1:0] COL_ONE = CW'(1);

  // window columns: 0..2 one column left, 3..5 two columns left (older, newer, current row)
  box3_pkg::pix_t win [6];

  logic [CW:0]                  last_col;
  logic [box3_pkg::ROW_W-1:0]   last_row;
  logic [box3_pkg::ROW_W-1:0]   prev_row;
  logic                         deep_row;
  logic                         at_last_col;
  logic                         at_last_row;
  box3_pkg::pix_t               mean;

  // rounded mean of nine channel values
  function automatic logic [box3_pkg::CH_W-1:0] mean9(input logic [8:0][box3_pkg::CH_W-1:0] v);
    logic [box3_pkg::SUM_W-1:0]   sum;
    logic [2*box3_pkg::SUM_W-1:0] prod;
    sum = box3_pkg::ROUND_BIAS;
    for (int i = 0; i < 9; i++) begin
      sum = sum + box3_pkg::SUM_W'(v[i]);
    end
    prod = (2*box3_pkg::SUM_W)'(sum) * (2*box3_pkg::SUM_W)'(box3_pkg::RECIP9);
    return prod[box3_pkg::RECIP_SHIFT +: box3_pkg::CH_W];
  endfunction

  assign mean.red   = mean9({win[3].red,   win[0].red,   s1_older.red,
                             win[4].red,   win[1].red,   s1_newer.red,
                             win[5].red,   win[2].red,   s1_pix.red});
  assign mean.green = mean9({win[3].green, win[0].green, s1_older.green,
                             win[4].green, win[1].green, s1_newer.green,
                             win[5].green, win[2].green, s1_pix.green});
  assign mean.blue  = mean9({win[3].blue,  win[0].blue,  s1_older.blue,
                             win[4].blue,  win[1].blue,  s1_newer.blue,
                             win[5].blue,  win[2].blue,  s1_pix.blue});

  // position flags
  assign last_col    = eff_width - 1'b1;
  assign last_row    = eff_height - 1'b1;
  assign prev_row    = s1_row - 1'b1;
  assign deep_row    = s1_row >= box3_pkg::ROW_W'(2);
  assign at_last_col = {1'b0, s1_col} == last_col;
  assign at_last_row = s1_row == last_row;

  // candidate results in delivery order
  always_comb begin
    new_bundle.slot[0].pix    = (s1_col == COL_ONE) ? win[1] : mean;
    new_bundle.slot[0].row    = prev_row;
    new_bundle.slot[0].column = box3_pkg::COL_OUT_W'(s1_col - COL_ONE);
    new_bundle.mask[0]        = deep_row && (s1_col != '0);

    new_bundle.slot[1].pix    = s1_newer;
    new_bundle.slot[1].row    = prev_row;
    new_bundle.slot[1].column = box3_pkg::COL_OUT_W'(last_col);
    new_bundle.mask[1]        = deep_row && at_last_col;

    new_bundle.slot[2].pix    = s1_pix;
    new_bundle.slot[2].row    = s1_row;
    new_bundle.slot[2].column = box3_pkg::COL_OUT_W'(s1_col);
    new_bundle.mask[2]        = (s1_row == '0) || at_last_row;

    new_bundle.frame_end      = at_last_row && at_last_col;
  end

  // a pixel with no result leaves without waiting for the output side
  assign s1_advance  = s1_valid && ((new_bundle.mask == '0) || bundle_free);
  assign bundle_load = s1_valid && (new_bundle.mask != '0) && bundle_free;

  // shift the window as the pixel leaves
  always_ff @(posedge clk) begin
    if (s1_advance) begin
      win[3] <= win[0];
      win[4] <= win[1];
      win[5] <= win[2];
      win[0] <= s1_older;
      win[1] <= s1_newer;
      win[2] <= s1_pix;
    end
  end

endmodule

/* design/box3_emit.sv */
// result register that hands out the results of one pixel one transfer at a time
module box3_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic              bundle_load,
  input  box3_pkg::bundle_t new_bundle,
  output logic              bundle_free,
  box3_res_if.source        results
);

  box3_pkg::result_t [box3_pkg::NSLOT-1:0] slot;
  logic [box3_pkg::NSLOT-1:0]              mask;
  logic                                    frame_end;
  logic [box3_pkg::NSLOT-1:0]              sel;
  logic [box3_pkg::NSLOT-1:0]              rest;
  box3_pkg::result_t                       cur;
  logic                                    xfer;

  // lowest pending slot goes first
  always_comb begin
    sel = '0;
    cur = slot[0];
    priority if (mask[0]) begin
      sel = 3'b001;
      cur = slot[0];
    end else if (mask[1]) begin
      sel = 3'b010;
      cur = slot[1];
    end else if (mask[2]) begin
      sel = 3'b100;
      cur = slot[2];
    end else begin
      sel = '0;
    end
  end

  assign rest        = mask & ~sel;
  assign xfer        = results.valid && results.ready;
  assign bundle_free = (mask == '0) || (xfer && (rest == '0));

  assign results.valid        = mask != '0;
  assign results.red_out      = cur.pix.red;
  assign results.green_out    = cur.pix.green;
  assign results.blue_out     = cur.pix.blue;
  assign results.pixel_row    = cur.row;
  assign results.pixel_column = cur.column;
  assign results.last_of_item = rest == '0;
  assign results.frame_end    = frame_end && (rest == '0);

  // pending mask
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (bundle_load) begin
      mask <= new_bundle.mask;
    end else if (xfer) begin
      mask <= rest;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (bundle_load) begin
      slot      <= new_bundle.slot;
      frame_end <= new_bundle.frame_end;
    end
  end

endmodule

/* design/box_filter_3x3_rgb.sv */
// top level of the streaming 3x3 rgb box filter
//
// pixels arrive on the pixels channel in raster order, one per transfer;
// frame width and height are set through the apb port (registers at 0 and 4)
// by the user only while the block is idle, which the block does not enforce;
// each interior pixel leaves as the rounded mean of its 3x3 neighborhood,
// border pixels leave unchanged, every result carrying its row and column, a
// last-of-item flag and a frame-end flag. an input pixel yields zero to three
// results: results for a row come out while the row below it streams in, and
// the last row also passes through. throughput: one pixel per clock while the
// result side keeps up; a pixel with two or three results holds the output
// register until each has gone out on the single result port. the input
// register and the result register part the two channels, so a pixel is
// taken while a finished result waits; when the receiver stalls the result
// holds and the input stops once both registers are full. reset clears
// counters and valid state and restores 800 x 600; line stores need no
// clearing since an entry feeds a result only once the frame has written it.
module box_filter_3x3_rgb #(
  parameter int MAX_WIDTH = box3_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [box3_pkg::APB_AW-1:0] paddr,
  input  logic [box3_pkg::APB_DW-1:0] pwdata,
  output logic [box3_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  box3_pix_if.sink                    pixels,
  box3_res_if.source                  results
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [CW:0]                  eff_width;
  logic [box3_pkg::FH_W-1:0]    eff_height;
  logic                         s1_valid;
  logic                         s1_advance;
  box3_pkg::pix_t               s1_pix;
  box3_pkg::pix_t               s1_older;
  box3_pkg::pix_t               s1_newer;
  logic [box3_pkg::ROW_W-1:0]   s1_row;
  logic [CW-1:0]                s1_col;
  logic                         bundle_free;
  logic                         bundle_load;
  box3_pkg::bundle_t            new_bundle;

  box3_regs #(.MAX_WIDTH(MAX_WIDTH)) u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .eff_width  (eff_width),
    .eff_height (eff_height)
  );

  box3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .pixels     (pixels),
    .eff_width  (eff_width),
    .eff_height (eff_height),
    .s1_advance (s1_advance),
    .s1_valid   (s1_valid),
    .s1_pix     (s1_pix),
    .s1_older   (s1_older),
    .s1_newer   (s1_newer),
    .s1_row     (s1_row),
    .s1_col     (s1_col)
  );

  box3_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk         (clk),
    .s1_valid    (s1_valid),
    .s1_pix      (s1_pix),
    .s1_older    (s1_older),
    .s1_newer    (s1_newer),
    .s1_row      (s1_row),
    .s1_col      (s1_col),
    .eff_width   (eff_width),
    .eff_height  (eff_height),
    .bundle_free (bundle_free),
    .s1_advance  (s1_advance),
    .bundle_load (bundle_load),
    .new_bundle  (new_bundle)
  );

  box3_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .bundle_load (bundle_load),
    .new_bundle  (new_bundle),
    .bundle_free (bundle_free),
    .results     (results)
  );

endmodule

/* design/box3_check.sv */
// port-level checks for the box filter, bound to the top level
module box3_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           res_valid,
  input logic                           res_ready,
  input logic [box3_pkg::CH_W-1:0]      res_red,
  input logic [box3_pkg::CH_W-1:0]      res_green,
  input logic [box3_pkg::CH_W-1:0]      res_blue,
  input logic [box3_pkg::ROW_W-1:0]     res_row,
  input logic [box3_pkg::COL_OUT_W-1:0] res_column,
  input logic                           res_last,
  input logic                           res_frame_end
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result withdrawn while stalled");

  // a stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=>
      $stable(res_red) && $stable(res_green) && $stable(res_blue) &&
      $stable(res_row) && $stable(res_column) && $stable(res_last) &&
      $stable(res_frame_end))
    else $error("result payload changed while stalled");

  // after reset nothing is pending and the input is open
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid && in_ready)
    else $error("pipeline not empty after reset");

  // the end of a frame always closes the results of its pixel
  a_frame_end_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_frame_end |-> res_last)
    else $error("frame end on a result that is not the last of its pixel");

endmodule

bind box_filter_3x3_rgb box3_check u_check (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (pixels.ready),
  .res_valid     (results.valid),
  .res_ready     (results.ready),
  .res_red       (results.red_out),
  .res_green     (results.green_out),
  .res_blue      (results.blue_out),
  .res_row       (results.pixel_row),
  .res_column    (results.pixel_column),
  .res_last      (results.last_of_item),
  .res_frame_end (results.frame_end)
);
